// ===== hw/rtl/hmm_scaled_forward_backward_core_macros.svh =====
// Assertion macros shared by the forward-backward core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef HMM_SCALED_FORWARD_BACKWARD_CORE_MACROS_SVH
`define HMM_SCALED_FORWARD_BACKWARD_CORE_MACROS_SVH

// same-cycle implication
`define HSFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSFB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hsfb_pkg.sv =====
// Package for the scaled HMM forward-backward core: sizes, codes, types, ln table.
// No dependencies.
package hsfb_pkg;

   localparam int NUM_STATES  = 8;
   localparam int NUM_SYMBOLS = 64;
   localparam int MAX_LEN     = 256;

   // request / response field widths
   localparam int OP_W   = 3;
   localparam int ROW_W  = 4;
   localparam int COL_W  = 6;
   localparam int Q_W    = 24;
   localparam int SYM_W  = 6;
   localparam int TI_W   = 8;
   localparam int SI_W   = 4;
   localparam int PROB_W = 32;
   localparam int LL_W   = 32;

   localparam int ST_LOG = $clog2(NUM_STATES);
   localparam int IDX_W  = (NUM_STATES > 1) ? ST_LOG : 1;

   localparam int TR_DEPTH = NUM_STATES * NUM_STATES;
   localparam int EM_DEPTH = NUM_STATES * NUM_SYMBOLS;
   localparam int TR_AW    = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
   localparam int EM_AW    = (EM_DEPTH > 1) ? $clog2(EM_DEPTH) : 1;
   localparam int IN_AW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int SC_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam int Q_FRAC  = 23;
   localparam int AB_W    = 25;                 // (A*B) >> 23
   localparam int MUL_A_W = 25 + ST_LOG;        // widest left operand: acc >> 23
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W;
   localparam int RAW_W   = PROD_W - Q_FRAC;
   localparam int SUM_W   = RAW_W + ST_LOG;
   localparam int QUO_W   = 32;

   localparam logic [Q_W-1:0]    MAX24    = 24'hFF_FFFF;
   localparam logic [PROB_W-1:0] ONE_Q824 = 32'h0100_0000;
   localparam logic [15:0]       LN2_Q16  = 16'd45426;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_STATES - 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_TRANS = 3'd0,
      OP_LOAD_EMIS  = 3'd1,
      OP_LOAD_INIT  = 3'd2,
      OP_FORWARD    = 3'd3,
      OP_BACKWARD   = 3'd4
   } hsfb_op_type;

   typedef enum logic [2:0] {
      MUL_INIT_EMIS,
      MUL_TRANS_ALPHA,
      MUL_ACC_EMIS,
      MUL_TRANS_EMIS,
      MUL_AB_BETA
   } hsfb_mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD
   } hsfb_acc_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_F_START, S_F_INIT_RD, S_F_INIT_MUL, S_F_INIT_RAW,
      S_F_TA_RD, S_F_TA_MUL, S_F_TA_ACC,
      S_F_EM_RD, S_F_EM_MUL, S_F_EM_RAW,
      S_F_SCALE, S_F_LN_START, S_LN_NORM, S_LN_MUL, S_LN_ADD,
      S_F_DIV_START, S_F_DIV_WAIT,
      S_B_START, S_B_SCALE, S_B_RD, S_B_MUL1, S_B_AB, S_B_MUL2, S_B_ACC,
      S_B_DIV_START, S_B_DIV_WAIT, S_B_COMMIT,
      S_EMIT
   } hsfb_state_type;

   typedef struct packed {
      logic              latch;
      logic              load_wr;
      logic              mul_en;
      hsfb_mul_sel_type  mul_sel;
      hsfb_acc_op_type   acc_op;
      logic              raw_wr;
      logic              sum_clear;
      logic              ab_wr;
      logic              scale_fix;
      logic              scale_get;
      logic              ll_clear;
      logic              ln_start;
      logic              ln_step;
      logic              ln_mul;
      logic              ln_add;
      logic              beta_ones;
      logic              div_start;
      logic              alpha_wr;
      logic              nb_wr;
      logic              beta_commit;
      logic              out_load;
      logic [IDX_W-1:0]  i;
      logic [IDX_W-1:0]  j;
   } hsfb_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            first;
      logic            scale_zero;
      logic            ln_done;
      logic            div_busy;
      logic            div_done;
      logic            out_free;
   } hsfb_status_type;

   // ln(1 + k/32) in Q0.16
   function automatic logic [15:0] ln_tab_f(input logic [5:0] k);
      logic [15:0] r;
      case (k)
         6'd0:  r = 16'd0;     6'd1:  r = 16'd2017;  6'd2:  r = 16'd3973;
         6'd3:  r = 16'd5873;  6'd4:  r = 16'd7719;  6'd5:  r = 16'd9515;
         6'd6:  r = 16'd11262; 6'd7:  r = 16'd12965; 6'd8:  r = 16'd14624;
         6'd9:  r = 16'd16242; 6'd10: r = 16'd17822; 6'd11: r = 16'd19364;
         6'd12: r = 16'd20870; 6'd13: r = 16'd22343; 6'd14: r = 16'd23784;
         6'd15: r = 16'd25193; 6'd16: r = 16'd26573; 6'd17: r = 16'd27924;
         6'd18: r = 16'd29248; 6'd19: r = 16'd30546; 6'd20: r = 16'd31819;
         6'd21: r = 16'd33067; 6'd22: r = 16'd34292; 6'd23: r = 16'd35494;
         6'd24: r = 16'd36675; 6'd25: r = 16'd37835; 6'd26: r = 16'd38975;
         6'd27: r = 16'd40095; 6'd28: r = 16'd41197; 6'd29: r = 16'd42280;
         6'd30: r = 16'd43346; 6'd31: r = 16'd44394; 6'd32: r = 16'd45426;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/hsfb_req_if.sv =====
// Request channel of the forward-backward core: valid/ready plus item fields.
// Depends on hsfb_pkg.
interface hsfb_req_if import hsfb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [ROW_W-1:0] row;
   logic [COL_W-1:0] column;
   logic [Q_W-1:0]   value;
   logic [SYM_W-1:0] symbol;
   logic [TI_W-1:0]  time_index;
   logic             first;
   logic             new_batch;

   modport source (output valid, op, row, column, value, symbol, time_index, first,
                   new_batch, input ready);
   modport sink   (input valid, op, row, column, value, symbol, time_index, first,
                   new_batch, output ready);
endinterface

// ===== hw/rtl/hsfb_rsp_if.sv =====
// Response channel of the forward-backward core: valid/ready plus result fields.
// Depends on hsfb_pkg.
interface hsfb_rsp_if import hsfb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SI_W-1:0]          state_index;
   logic [PROB_W-1:0]        prob;
   logic [Q_W-1:0]           scale;
   logic signed [LL_W-1:0]   log_likelihood;
   logic                     zero_scale;
   logic                     last;

   modport source (output valid, state_index, prob, scale, log_likelihood, zero_scale,
                   last, input ready);
   modport sink   (input valid, state_index, prob, scale, log_likelihood, zero_scale,
                   last, output ready);
endinterface

// ===== hw/rtl/hmm_scaled_forward_backward_core.sv =====
// Top level of the scaled HMM forward-backward core: sequencer plus datapath.
// Depends on hsfb_pkg, hsfb_req_if, hsfb_rsp_if, hsfb_ctrl and hsfb_dp.
//
//   channel    dir  handshake        carries
//   req_chan   in   valid/ready      op, row, column, value, symbol, time_index, first,
//                                    new_batch
//   rsp_chan   out  valid/ready      state_index, prob, scale, log_likelihood,
//                                    zero_scale, last
//
// One request at a time. A forward step and a backward step are both bound by the
// single shared multiplier and the one-bit-per-cycle divider; each is followed by
// handing out N results (N states).
// Synchronous active-high reset; no clearing pass, tables hold garbage until loaded.
// A stalled response holds the sequencer in its output phase; the last result
// sits in the response register while the next request is taken.
module hmm_scaled_forward_backward_core import hsfb_pkg::*; (
   input logic         clock,
   input logic         reset,
   hsfb_req_if.sink    req_chan,
   hsfb_rsp_if.source  rsp_chan
);
   hsfb_cmd_type    cmd;
   hsfb_status_type status;
   logic            req_ready;

   hsfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hsfb_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_chan.op),
      .req_row            (req_chan.row),
      .req_column         (req_chan.column),
      .req_value          (req_chan.value),
      .req_symbol         (req_chan.symbol),
      .req_time_index     (req_chan.time_index),
      .req_first          (req_chan.first),
      .req_new_batch      (req_chan.new_batch),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_state_index    (rsp_chan.state_index),
      .rsp_prob           (rsp_chan.prob),
      .rsp_scale          (rsp_chan.scale),
      .rsp_log_likelihood (rsp_chan.log_likelihood),
      .rsp_zero_scale     (rsp_chan.zero_scale),
      .rsp_last           (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;
endmodule

// ===== hw/rtl/hsfb_ram.sv =====
// Generic single-port RAM, write or read each cycle, registered read data.
// No dependencies.
module hsfb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/hsfb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit saturating quotient.
// Depends on hsfb_pkg.
module hsfb_div import hsfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ACC_W-1:0]   dividend,
   input  logic [Q_W-1:0]     divisor,
   output logic               busy,
   output logic               done,
   output logic [QUO_W-1:0]   quotient
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [Q_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [Q_W-1:0]   dsr_ff, dsr_in;
   logic [Q_W:0]     trial;
   logic [ACC_W-QUO_W-1:0] hi;

   assign hi    = dividend[ACC_W-1:QUO_W];
   assign trial = {rem_ff, quo_ff[QUO_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         dsr_in = divisor;
         if (divisor == '0) begin
            quo_in  = '0;
            done_in = 1'b1;
         end else if (hi >= (ACC_W-QUO_W)'(divisor)) begin
            // quotient would not fit in 32 bits
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = Q_W'(hi);
            quo_in  = dividend[QUO_W-1:0];
            cnt_in  = 6'(QUO_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = Q_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[Q_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hw/rtl/hsfb_ctrl.sv =====
// Sequencer of the forward-backward core: walks the MAC, ln and divide steps.
// Depends on hsfb_pkg and the assertion macro header.
`include "hmm_scaled_forward_backward_core_macros.svh"

module hsfb_ctrl import hsfb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hsfb_status_type status,
   output hsfb_cmd_type    cmd
);
   hsfb_state_type   state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.mul_sel = MUL_INIT_EMIS;
      cmd.acc_op  = ACC_HOLD;
      cmd.i       = i_ff;
      cmd.j       = j_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            i_in = '0;
            j_in = '0;
            case (status.op)
               OP_LOAD_TRANS, OP_LOAD_EMIS, OP_LOAD_INIT: begin
                  cmd.load_wr = 1'b1;
                  state_in    = S_IDLE;
               end
               OP_FORWARD:  state_in = S_F_START;
               OP_BACKWARD: state_in = S_B_START;
               default:     state_in = S_IDLE;
            endcase
         end
         // forward pass: raw alpha per target state
         S_F_START: begin
            cmd.ll_clear  = 1'b0;
            cmd.sum_clear = 1'b1;
            cmd.acc_op    = ACC_CLEAR;
            state_in      = status.first ? S_F_INIT_RD : S_F_TA_RD;
         end
         S_F_INIT_RD: state_in = S_F_INIT_MUL;
         S_F_INIT_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INIT_EMIS;
            state_in    = S_F_INIT_RAW;
         end
         S_F_INIT_RAW: begin
            cmd.raw_wr = 1'b1;
            if (j_ff == LAST_IDX) begin
               state_in = S_F_SCALE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_F_INIT_RD;
            end
         end
         S_F_TA_RD: state_in = S_F_TA_MUL;
         S_F_TA_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TRANS_ALPHA;
            state_in    = S_F_TA_ACC;
         end
         S_F_TA_ACC: begin
            cmd.acc_op = ACC_ADD;
            if (i_ff == LAST_IDX) begin
               state_in = S_F_EM_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_F_TA_RD;
            end
         end
         S_F_EM_RD: state_in = S_F_EM_MUL;
         S_F_EM_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ACC_EMIS;
            state_in    = S_F_EM_RAW;
         end
         S_F_EM_RAW: begin
            cmd.raw_wr = 1'b1;
            cmd.acc_op = ACC_CLEAR;
            i_in       = '0;
            if (j_ff == LAST_IDX) begin
               state_in = S_F_SCALE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_F_TA_RD;
            end
         end
         S_F_SCALE: begin
            cmd.scale_fix = 1'b1;
            state_in      = S_F_LN_START;
         end
         S_F_LN_START: begin
            j_in = '0;
            if (status.scale_zero) begin
               state_in = S_F_DIV_START;
            end else begin
               cmd.ln_start = 1'b1;
               state_in     = S_LN_NORM;
            end
         end
         S_LN_NORM: begin
            if (status.ln_done) begin
               state_in = S_LN_MUL;
            end else begin
               cmd.ln_step = 1'b1;
            end
         end
         S_LN_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in   = S_LN_ADD;
         end
         S_LN_ADD: begin
            cmd.ln_add = 1'b1;
            state_in   = S_F_DIV_START;
         end
         S_F_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_F_DIV_WAIT;
         end
         S_F_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.alpha_wr = 1'b1;
               if (j_ff == LAST_IDX) begin
                  j_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_F_DIV_START;
               end
            end
         end
         // backward pass: beta per source state
         S_B_START: begin
            cmd.beta_ones = status.first;
            state_in      = S_B_SCALE;
         end
         S_B_SCALE: begin
            cmd.scale_get = 1'b1;
            cmd.acc_op    = ACC_CLEAR;
            state_in      = S_B_RD;
         end
         S_B_RD: state_in = S_B_MUL1;
         S_B_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TRANS_EMIS;
            state_in    = S_B_AB;
         end
         S_B_AB: begin
            cmd.ab_wr = 1'b1;
            state_in  = S_B_MUL2;
         end
         S_B_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AB_BETA;
            state_in    = S_B_ACC;
         end
         S_B_ACC: begin
            cmd.acc_op = ACC_ADD;
            if (j_ff == LAST_IDX) begin
               j_in     = '0;
               state_in = S_B_DIV_START;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_B_RD;
            end
         end
         S_B_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_B_DIV_WAIT;
         end
         S_B_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.nb_wr  = 1'b1;
               cmd.acc_op = ACC_CLEAR;
               if (i_ff == LAST_IDX) begin
                  state_in = S_B_COMMIT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_B_RD;
               end
            end
         end
         S_B_COMMIT: begin
            cmd.beta_commit = 1'b1;
            j_in            = '0;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (j_ff == LAST_IDX) begin
                  j_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // ll_clear stays low; the datapath clears the total at the top of a forward step when new_batch is set
      if (state_ff == S_F_START) begin
         cmd.ll_clear = status.first | ~status.first ? 1'b0 : 1'b0;
      end
   end

   `HSFB_ASSERT_NXT(a_accept_drops_ready, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request was taken")
   `HSFB_ASSERT_IMP(a_div_start_free, clock, reset, cmd.div_start, !status.div_busy, "divider started while busy")
   `HSFB_ASSERT_IMP(a_out_load_free, clock, reset, cmd.out_load, status.out_free, "response register overwritten")
   `HSFB_ASSERT_NXT(a_last_to_idle, clock, reset, cmd.out_load && (j_ff == LAST_IDX), state_ff == S_IDLE, "sequencer did not return to idle after last result")
endmodule

// ===== hw/rtl/hsfb_dp.sv =====
// Datapath of the forward-backward core: tables, MAC, ln unit, divider, response register.
// Depends on hsfb_pkg, hsfb_ram and hsfb_div.
module hsfb_dp import hsfb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [OP_W-1:0]        req_op,
   input  logic [ROW_W-1:0]       req_row,
   input  logic [COL_W-1:0]       req_column,
   input  logic [Q_W-1:0]         req_value,
   input  logic [SYM_W-1:0]       req_symbol,
   input  logic [TI_W-1:0]        req_time_index,
   input  logic                   req_first,
   input  logic                   req_new_batch,
   input  hsfb_cmd_type           cmd,
   output hsfb_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SI_W-1:0]        rsp_state_index,
   output logic [PROB_W-1:0]      rsp_prob,
   output logic [Q_W-1:0]         rsp_scale,
   output logic signed [LL_W-1:0] rsp_log_likelihood,
   output logic                   rsp_zero_scale,
   output logic                   rsp_last
);
   // latched request
   logic [OP_W-1:0]  op_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic [Q_W-1:0]   val_ff;
   logic [SYM_W-1:0] sym_ff;
   logic [TI_W-1:0]  ti_ff;
   logic             first_ff;
   logic             newb_ff;

   logic [TR_AW-1:0] tr_addr;
   logic [EM_AW-1:0] em_addr;
   logic [IN_AW-1:0] in_addr;
   logic             tr_we, em_we, in_we, sc_we;
   logic [Q_W-1:0]   tr_rdata, em_rdata, in_rdata, sc_rdata, emis;
   logic             row_ok, ti_ok, fwd;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [AB_W-1:0]    ab_ff;
   logic [RAW_W-1:0]   raw_ff [NUM_STATES];
   logic [SUM_W-1:0]   sum_ff;
   logic [Q_W-1:0]     scale_ff, scale_sat;
   logic [Q_W-1:0]     alpha_ff [NUM_STATES];
   logic [PROB_W-1:0]  beta_ff [NUM_STATES];
   logic [PROB_W-1:0]  nb_ff [NUM_STATES];

   // ln unit
   logic [Q_W-1:0]         ln_x_ff;
   logic [4:0]             ln_p_ff;
   logic                   ln_done;
   logic [15:0]            tab_lo, tab_hi, tab_diff;
   logic [33:0]            ip;
   logic [20:0]            ln_neg;
   logic [15:0]            interp_ff;
   logic signed [23:0]     base_ff;
   logic signed [23:0]     ln_term;
   logic signed [33:0]     ll_sum;
   logic signed [LL_W-1:0] ll_ff;

   logic [ACC_W-1:0] div_dividend;
   logic             div_busy, div_done;
   logic [QUO_W-1:0] div_quo;

   logic                   rsp_valid_ff;
   logic [SI_W-1:0]        rsp_si_ff;
   logic [PROB_W-1:0]      rsp_prob_ff;
   logic [Q_W-1:0]         rsp_scale_ff;
   logic signed [LL_W-1:0] rsp_ll_ff;
   logic                   rsp_zero_ff;
   logic                   rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_op;
         row_ff   <= req_row;
         col_ff   <= req_column;
         val_ff   <= req_value;
         sym_ff   <= req_symbol;
         ti_ff    <= req_time_index;
         first_ff <= req_first;
         newb_ff  <= req_new_batch;
      end
   end

   assign fwd    = (op_ff == OP_FORWARD);
   assign row_ok = (row_ff < NUM_STATES);
   assign ti_ok  = (ti_ff < MAX_LEN);

   always_comb begin
      if (cmd.load_wr) begin
         tr_addr = TR_AW'(row_ff * NUM_STATES + col_ff);
         em_addr = EM_AW'(row_ff * NUM_SYMBOLS + col_ff);
         in_addr = IN_AW'(row_ff);
      end else begin
         tr_addr = TR_AW'(cmd.i * NUM_STATES + cmd.j);
         em_addr = EM_AW'(cmd.j * NUM_SYMBOLS + sym_ff);
         in_addr = IN_AW'(cmd.j);
      end
   end

   assign tr_we = cmd.load_wr && (op_ff == OP_LOAD_TRANS) && row_ok && (col_ff < NUM_STATES);
   assign em_we = cmd.load_wr && (op_ff == OP_LOAD_EMIS) && row_ok && (col_ff < NUM_SYMBOLS);
   assign in_we = cmd.load_wr && (op_ff == OP_LOAD_INIT) && row_ok;
   assign sc_we = cmd.scale_fix && ti_ok;

   hsfb_ram #(.WIDTH(Q_W), .DEPTH(TR_DEPTH)) u_trans (
      .clock(clock), .we(tr_we), .addr(tr_addr), .wdata(val_ff), .rdata(tr_rdata));
   hsfb_ram #(.WIDTH(Q_W), .DEPTH(EM_DEPTH)) u_emis (
      .clock(clock), .we(em_we), .addr(em_addr), .wdata(val_ff), .rdata(em_rdata));
   hsfb_ram #(.WIDTH(Q_W), .DEPTH(NUM_STATES)) u_init (
      .clock(clock), .we(in_we), .addr(in_addr), .wdata(val_ff), .rdata(in_rdata));
   hsfb_ram #(.WIDTH(Q_W), .DEPTH(MAX_LEN)) u_scale (
      .clock(clock), .we(sc_we), .addr(ti_ff[SC_AW-1:0]), .wdata(scale_sat),
      .rdata(sc_rdata));

   // symbol past the alphabet reads as zero emission
   assign emis = (sym_ff < NUM_SYMBOLS) ? em_rdata : '0;

   always_comb begin
      case (cmd.mul_sel)
         MUL_INIT_EMIS: begin
            mul_a = MUL_A_W'(in_rdata);
            mul_b = MUL_B_W'(emis);
         end
         MUL_TRANS_ALPHA: begin
            mul_a = MUL_A_W'(tr_rdata);
            mul_b = MUL_B_W'(alpha_ff[cmd.i]);
         end
         MUL_ACC_EMIS: begin
            mul_a = MUL_A_W'(acc_ff >> Q_FRAC);
            mul_b = MUL_B_W'(emis);
         end
         MUL_TRANS_EMIS: begin
            mul_a = MUL_A_W'(tr_rdata);
            mul_b = MUL_B_W'(emis);
         end
         MUL_AB_BETA: begin
            mul_a = MUL_A_W'(ab_ff);
            mul_b = beta_ff[cmd.j];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign scale_sat = (sum_ff > SUM_W'(MAX24)) ? MAX24 : sum_ff[Q_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      case (cmd.acc_op)
         ACC_CLEAR: acc_ff <= '0;
         ACC_ADD:   acc_ff <= acc_ff + prod_ff;
         default:   acc_ff <= acc_ff;
      endcase
      if (cmd.ab_wr) begin
         ab_ff <= AB_W'(prod_ff >> Q_FRAC);
      end
      if (cmd.raw_wr) begin
         raw_ff[cmd.j] <= RAW_W'(prod_ff >> Q_FRAC);
      end
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.raw_wr) begin
         sum_ff <= sum_ff + SUM_W'(prod_ff >> Q_FRAC);
      end
      if (cmd.scale_fix) begin
         scale_ff <= scale_sat;
      end else if (cmd.scale_get) begin
         scale_ff <= ti_ok ? sc_rdata : '0;
      end
      if (cmd.nb_wr) begin
         nb_ff[cmd.i] <= div_quo;
      end
   end

   // alpha and beta vectors reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STATES; k++) begin
            alpha_ff[k] <= '0;
            beta_ff[k]  <= '0;
         end
      end else begin
         if (cmd.alpha_wr) begin
            alpha_ff[cmd.j] <= (div_quo > QUO_W'(MAX24)) ? MAX24 : div_quo[Q_W-1:0];
         end
         if (cmd.beta_ones) begin
            for (int k = 0; k < NUM_STATES; k++) begin
               beta_ff[k] <= ONE_Q824;
            end
         end else if (cmd.beta_commit) begin
            for (int k = 0; k < NUM_STATES; k++) begin
               beta_ff[k] <= nb_ff[k];
            end
         end
      end
   end

   // ln(scale): normalize one bit per cycle, then table plus linear interpolation
   assign ln_done  = ln_x_ff[Q_W-1] || (ln_p_ff == 5'd0);
   assign tab_lo   = ln_tab_f({1'b0, ln_x_ff[22:18]});
   assign tab_hi   = ln_tab_f({1'b0, ln_x_ff[22:18]} + 6'd1);
   assign tab_diff = tab_hi - tab_lo;
   assign ip       = 34'(tab_diff) * 34'(ln_x_ff[17:0]);
   assign ln_neg   = 21'(5'd23 - ln_p_ff) * 21'(LN2_Q16);
   assign ln_term  = base_ff + $signed({8'b0, interp_ff});
   assign ll_sum   = 34'(ll_ff) + 34'(ln_term);

   always_ff @(posedge clock) begin
      if (cmd.ln_start) begin
         ln_x_ff <= scale_ff;
         ln_p_ff <= 5'd23;
      end else if (cmd.ln_step && !ln_done) begin
         ln_x_ff <= {ln_x_ff[Q_W-2:0], 1'b0};
         ln_p_ff <= ln_p_ff - 5'd1;
      end
      if (cmd.ln_mul) begin
         interp_ff <= ip[33:18];
         base_ff   <= $signed(24'(tab_lo) - 24'(ln_neg));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ll_ff <= '0;
      end else if (cmd.ll_clear || (cmd.sum_clear && newb_ff)) begin
         ll_ff <= '0;
      end else if (cmd.ln_add) begin
         if (ll_sum > 34'sd2147483647) begin
            ll_ff <= 32'sh7FFF_FFFF;
         end else if (ll_sum < -34'sd2147483648) begin
            ll_ff <= 32'sh8000_0000;
         end else begin
            ll_ff <= ll_sum[LL_W-1:0];
         end
      end
   end

   assign div_dividend = fwd ? {raw_ff[cmd.j], {Q_FRAC{1'b0}}} : acc_ff;

   hsfb_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(div_dividend),
      .divisor(scale_ff), .busy(div_busy), .done(div_done), .quotient(div_quo));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_si_ff    <= SI_W'(cmd.j);
         rsp_prob_ff  <= fwd ? PROB_W'({alpha_ff[cmd.j], 1'b0}) : beta_ff[cmd.j];
         rsp_scale_ff <= scale_ff;
         rsp_ll_ff    <= ll_ff;
         rsp_zero_ff  <= (scale_ff == '0);
         rsp_last_ff  <= (cmd.j == LAST_IDX);
      end
   end

   assign status.op         = op_ff;
   assign status.first      = first_ff;
   assign status.scale_zero = (scale_ff == '0);
   assign status.ln_done    = ln_done;
   assign status.div_busy   = div_busy;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_state_index    = rsp_si_ff;
   assign rsp_prob           = rsp_prob_ff;
   assign rsp_scale          = rsp_scale_ff;
   assign rsp_log_likelihood = rsp_ll_ff;
   assign rsp_zero_scale     = rsp_zero_ff;
   assign rsp_last           = rsp_last_ff;
endmodule
